### rtl/sipd_pkg.sv
// ----------------------------------------------------------------------------
// sipd_pkg
// Shared types and constants for the SIM icon pixel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sipd_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int ENTRY_BYTES   = 3;
    localparam int TABLE_BYTES   = TABLE_ENTRIES * ENTRY_BYTES;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // entry = addr / 3 for addr < 768, by reciprocal multiply
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;

    localparam int MAX_RUN = 8;

    localparam logic [2:0] HP_WIDTH  = 3'd0;
    localparam logic [2:0] HP_HEIGHT = 3'd1;
    localparam logic [2:0] HP_BPP    = 3'd2;
    localparam logic [2:0] HP_SKIP0  = 3'd3;
    localparam logic [2:0] HP_SKIP1  = 3'd4;
    localparam logic [2:0] HP_SKIP2  = 3'd5;
    localparam logic [2:0] HP_DATA   = 3'd6;

    localparam logic CMD_TABLE  = 1'b0;
    localparam logic CMD_IMAGE  = 1'b1;
    localparam logic MODE_BASIC = 1'b0;
    localparam logic MODE_COLOR = 1'b1;

    localparam logic [31:0] ARGB_WHITE = 32'hFFFF_FFFF;
    localparam logic [31:0] ARGB_BLACK = 32'hFF00_0000;
    localparam logic [7:0]  ALPHA      = 8'hFF;

    localparam logic [3:0] BPP_MIN = 4'd1;
    localparam logic [7:0] BPP_MAX = 8'd8;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CMD,
        ST_EXTRACT,
        ST_PUSH,
        ST_ERR
    } t_state;

    typedef struct packed {
        logic [15:0] acc;
        logic [3:0]  cnt;
        logic [3:0]  bpp;
    } t_unpack_req;

    typedef struct packed {
        logic [7:0] value;
        logic [3:0] next_cnt;
    } t_unpack_rsp;

endpackage

`default_nettype wire

### rtl/sipd_ram.sv
// ----------------------------------------------------------------------------
// sipd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sipd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                            i_clk,
    input  wire                            i_we,
    input  wire  [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]               i_wdata,
    input  wire                            i_re,
    input  wire  [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]               o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/sipd_unpack.sv
// ----------------------------------------------------------------------------
// sipd_unpack
// Shared bit extractor: takes the next pixel field off the bit accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module sipd_unpack (
    input  wire sipd_pkg::t_unpack_req i_req,
    output sipd_pkg::t_unpack_rsp      o_rsp
);

    logic [15:0] mask;
    logic [15:0] shifted;
    logic [3:0]  next_cnt;

    always_comb begin
        next_cnt       = i_req.cnt - i_req.bpp;
        mask           = (16'd1 << i_req.bpp) - 16'd1;
        shifted        = i_req.acc >> next_cnt;
        o_rsp.next_cnt = next_cnt;
        o_rsp.value    = shifted[7:0] & mask[7:0];
    end

endmodule

`default_nettype wire

### rtl/sim_icon_pixel_decoder.sv
// ----------------------------------------------------------------------------
// sim_icon_pixel_decoder
// Decodes SIM icon image bytes into ARGB pixels through a color lookup table.
// ----------------------------------------------------------------------------
// Channel   Dir  Bits            Contents
// s_axis    in   tdata[17:0]     data_byte, table_address
//                tuser, tlast    command, last_byte
// m_axis    out  tdata[47:0]     pixel_argb, pixel_index
//                tlast, tuser    last_of_run, {format_error, image_done}
// cfg       in   we, wdata       coding_mode
//
// Table write and header byte: accepted in ST_IDLE and applied in ST_CMD; a bad
// bits-per-pixel byte also passes through ST_ERR. Image byte: ST_CMD, then per pixel
// one extractor pass and one table read (ST_EXTRACT, ST_PUSH), up to MAX_RUN pixels.
// After reset a clearing pass zeroes the whole table;
// no transaction is accepted meanwhile. A stalled output holds the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module sim_icon_pixel_decoder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_wdata,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,  // [7:0] data_byte, [17:8] table_address
    input  wire         s_axis_tuser,  // [0] command
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,  // [31:0] pixel_argb, [47:32] pixel_index
    output logic [1:0]  m_axis_tuser,  // [0] image_done, [1] format_error
    output logic        m_axis_tlast
);

    localparam int IW = sipd_pkg::IDX_W;

    sipd_pkg::t_state r_state, n_state;

    logic              r_mode;
    logic [2:0]        r_hpos, n_hpos;
    logic [7:0]        r_width, n_width;
    logic [15:0]       r_total, n_total;
    logic [3:0]        r_bpp, n_bpp;
    logic [15:0]       r_pe, n_pe;
    logic [7:0]        r_carry, n_carry;
    logic [2:0]        r_ccnt, n_ccnt;
    logic              r_in_cmd, r_in_last;
    logic [7:0]        r_in_byte;
    logic [9:0]        r_in_addr;
    logic [15:0]       r_acc, n_acc;
    logic [3:0]        r_cnt, n_cnt;
    logic [3:0]        r_n, n_n;
    logic [IW-1:0]     r_clr;
    logic              r_pix_lastrun, n_pix_lastrun;
    logic              r_pix_done, n_pix_done;
    logic [15:0]       r_pix_idx, n_pix_idx;
    logic              r_pix_basic, n_pix_basic;
    logic              r_pix_bit, n_pix_bit;
    logic              r_pix_oor, n_pix_oor;
    logic              r_out_valid, n_out_valid;
    logic [31:0]       r_out_argb, n_out_argb;
    logic [15:0]       r_out_idx, n_out_idx;
    logic              r_out_last, n_out_last;
    logic              r_out_done, n_out_done;
    logic              r_out_err, n_out_err;

    logic              in_acc;
    logic              out_free;
    logic              img_skip;
    logic              bpp_ok;
    logic              finish;
    logic              tbl_we;
    logic [19:0]       div_prod;
    logic [7:0]        tbl_entry;
    logic [1:0]        tbl_comp;
    logic              tbl_in_range;
    logic [15:0]       pe_inc;
    logic [7:0]        carry_mask;

    sipd_pkg::t_unpack_req up_req;
    sipd_pkg::t_unpack_rsp up_rsp;

    logic [7:0]        rd_data [sipd_pkg::ENTRY_BYTES];
    logic [IW-1:0]     ram_waddr;
    logic [7:0]        ram_wdata;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == sipd_pkg::ST_IDLE);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign img_skip      = (r_bpp == 4'd0) || (r_pe >= r_total);
    assign bpp_ok        = (r_in_byte >= 8'(sipd_pkg::BPP_MIN))
                        && (r_in_byte <= sipd_pkg::BPP_MAX);
    assign pe_inc        = r_pe + 16'd1;
    assign carry_mask    = (8'd1 << r_cnt[2:0]) - 8'd1;

    assign div_prod     = 20'(r_in_addr) * 20'(sipd_pkg::DIV3_MUL);
    assign tbl_entry    = 8'(div_prod >> sipd_pkg::DIV3_SHIFT);
    assign tbl_comp     = 2'(r_in_addr - 10'(tbl_entry) * 10'(sipd_pkg::ENTRY_BYTES));
    assign tbl_in_range = (r_in_addr < 10'(sipd_pkg::TABLE_BYTES));
    assign tbl_we       = (r_state == sipd_pkg::ST_CMD) && (r_in_cmd == sipd_pkg::CMD_TABLE)
                       && tbl_in_range;

    assign up_req.acc = r_acc;
    assign up_req.cnt = r_cnt;
    assign up_req.bpp = r_bpp;

    sipd_unpack u_unpack (
        .i_req (up_req),
        .o_rsp (up_rsp)
    );

    assign ram_waddr = (r_state == sipd_pkg::ST_CLEAR) ? r_clr : tbl_entry[IW-1:0];
    assign ram_wdata = (r_state == sipd_pkg::ST_CLEAR) ? 8'd0 : r_in_byte;

    for (genvar g = 0; g < sipd_pkg::ENTRY_BYTES; g++) begin : g_bank
        sipd_ram #(
            .WIDTH (8),
            .DEPTH (sipd_pkg::TABLE_ENTRIES)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    ((r_state == sipd_pkg::ST_CLEAR) || (tbl_we && tbl_comp == 2'(g))),
            .i_waddr (ram_waddr),
            .i_wdata (ram_wdata),
            .i_re    (r_state == sipd_pkg::ST_EXTRACT),
            .i_raddr (up_rsp.value[IW-1:0]),
            .o_rdata (rd_data[g])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sipd_pkg::ST_CLEAR: begin
                if (r_clr == IW'(sipd_pkg::TABLE_ENTRIES - 1)) begin
                    n_state = sipd_pkg::ST_IDLE;
                end
            end
            sipd_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = sipd_pkg::ST_CMD;
                end
            end
            sipd_pkg::ST_CMD: begin
                n_state = sipd_pkg::ST_IDLE;
                if (r_in_cmd == sipd_pkg::CMD_IMAGE) begin
                    if (r_hpos == sipd_pkg::HP_BPP && !bpp_ok) begin
                        n_state = sipd_pkg::ST_ERR;
                    end else if (r_hpos == sipd_pkg::HP_DATA && !img_skip) begin
                        n_state = sipd_pkg::ST_EXTRACT;
                    end
                end
            end
            sipd_pkg::ST_EXTRACT: begin
                n_state = sipd_pkg::ST_PUSH;
            end
            sipd_pkg::ST_PUSH: begin
                if (out_free) begin
                    n_state = r_pix_lastrun ? sipd_pkg::ST_IDLE : sipd_pkg::ST_EXTRACT;
                end
            end
            sipd_pkg::ST_ERR: begin
                if (out_free) begin
                    n_state = sipd_pkg::ST_IDLE;
                end
            end
            default: n_state = sipd_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_hpos        = r_hpos;
        n_width       = r_width;
        n_total       = r_total;
        n_bpp         = r_bpp;
        n_pe          = r_pe;
        n_carry       = r_carry;
        n_ccnt        = r_ccnt;
        n_acc         = r_acc;
        n_cnt         = r_cnt;
        n_n           = r_n;
        n_pix_lastrun = r_pix_lastrun;
        n_pix_done    = r_pix_done;
        n_pix_idx     = r_pix_idx;
        n_pix_basic   = r_pix_basic;
        n_pix_bit     = r_pix_bit;
        n_pix_oor     = r_pix_oor;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_argb    = r_out_argb;
        n_out_idx     = r_out_idx;
        n_out_last    = r_out_last;
        n_out_done    = r_out_done;
        n_out_err     = r_out_err;
        finish        = 1'b0;

        case (r_state)
            sipd_pkg::ST_CMD: begin
                if (r_in_cmd == sipd_pkg::CMD_IMAGE) begin
                    finish = 1'b1;
                    case (r_hpos)
                        sipd_pkg::HP_WIDTH: begin
                            n_width = r_in_byte;
                            n_hpos  = sipd_pkg::HP_HEIGHT;
                        end
                        sipd_pkg::HP_HEIGHT: begin
                            n_total = 16'(r_width) * 16'(r_in_byte);
                            if (r_mode == sipd_pkg::MODE_BASIC) begin
                                n_bpp  = sipd_pkg::BPP_MIN;
                                n_hpos = sipd_pkg::HP_DATA;
                            end else begin
                                n_hpos = sipd_pkg::HP_BPP;
                            end
                        end
                        sipd_pkg::HP_BPP: begin
                            n_bpp  = bpp_ok ? r_in_byte[3:0] : 4'd0;
                            n_hpos = sipd_pkg::HP_SKIP0;
                            finish = bpp_ok;
                        end
                        sipd_pkg::HP_SKIP0: n_hpos = sipd_pkg::HP_SKIP1;
                        sipd_pkg::HP_SKIP1: n_hpos = sipd_pkg::HP_SKIP2;
                        sipd_pkg::HP_SKIP2: n_hpos = sipd_pkg::HP_DATA;
                        default: begin
                            if (!img_skip) begin
                                finish = 1'b0;
                                n_acc  = {r_carry, r_in_byte};
                                n_cnt  = 4'(r_ccnt) + 4'd8;
                                n_n    = 4'd0;
                            end
                        end
                    endcase
                end
            end
            sipd_pkg::ST_EXTRACT: begin
                n_cnt         = up_rsp.next_cnt;
                n_pix_idx     = r_pe;
                n_pix_done    = (pe_inc == r_total);
                n_pe          = pe_inc;
                n_n           = r_n + 4'd1;
                n_pix_lastrun = (up_rsp.next_cnt < r_bpp) || (pe_inc >= r_total)
                             || (r_n == 4'(sipd_pkg::MAX_RUN - 1));
                n_pix_basic   = (r_mode == sipd_pkg::MODE_BASIC);
                n_pix_bit     = up_rsp.value[0];
                n_pix_oor     = ({1'b0, up_rsp.value} >= 9'(sipd_pkg::TABLE_ENTRIES));
            end
            sipd_pkg::ST_PUSH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_pix_basic) begin
                        n_out_argb = r_pix_bit ? sipd_pkg::ARGB_WHITE : sipd_pkg::ARGB_BLACK;
                    end else if (r_pix_oor) begin
                        n_out_argb = sipd_pkg::ARGB_BLACK;
                    end else begin
                        n_out_argb = {sipd_pkg::ALPHA, rd_data[0], rd_data[1], rd_data[2]};
                    end
                    n_out_idx  = r_pix_idx;
                    n_out_last = r_pix_lastrun;
                    n_out_done = r_pix_done;
                    n_out_err  = 1'b0;
                    if (r_pix_lastrun) begin
                        finish = 1'b1;
                        if (r_pe >= r_total || r_cnt > 4'd7) begin
                            n_carry = 8'd0;
                            n_ccnt  = 3'd0;
                        end else begin
                            n_carry = r_acc[7:0] & carry_mask;
                            n_ccnt  = r_cnt[2:0];
                        end
                    end
                end
            end
            sipd_pkg::ST_ERR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_argb  = 32'd0;
                    n_out_idx   = 16'd0;
                    n_out_last  = 1'b0;
                    n_out_done  = 1'b0;
                    n_out_err   = 1'b1;
                    finish      = 1'b1;
                end
            end
            default: ;
        endcase

        if (finish && r_in_last) begin
            n_hpos  = sipd_pkg::HP_WIDTH;
            n_pe    = 16'd0;
            n_carry = 8'd0;
            n_ccnt  = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sipd_pkg::ST_CLEAR;
            r_mode      <= sipd_pkg::MODE_BASIC;
            r_hpos      <= sipd_pkg::HP_WIDTH;
            r_width     <= 8'd0;
            r_total     <= 16'd0;
            r_bpp       <= 4'd0;
            r_pe        <= 16'd0;
            r_carry     <= 8'd0;
            r_ccnt      <= 3'd0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hpos      <= n_hpos;
            r_width     <= n_width;
            r_total     <= n_total;
            r_bpp       <= n_bpp;
            r_pe        <= n_pe;
            r_carry     <= n_carry;
            r_ccnt      <= n_ccnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (r_state == sipd_pkg::ST_CLEAR) begin
                r_clr <= r_clr + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_cmd  <= s_axis_tuser;
            r_in_byte <= s_axis_tdata[7:0];
            r_in_addr <= s_axis_tdata[17:8];
            r_in_last <= s_axis_tlast;
        end
        r_acc         <= n_acc;
        r_cnt         <= n_cnt;
        r_n           <= n_n;
        r_pix_lastrun <= n_pix_lastrun;
        r_pix_done    <= n_pix_done;
        r_pix_idx     <= n_pix_idx;
        r_pix_basic   <= n_pix_basic;
        r_pix_bit     <= n_pix_bit;
        r_pix_oor     <= n_pix_oor;
        r_out_argb    <= n_out_argb;
        r_out_idx     <= n_out_idx;
        r_out_last    <= n_out_last;
        r_out_done    <= n_out_done;
        r_out_err     <= n_out_err;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_idx, r_out_argb};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = {r_out_err, r_out_done};

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == 48'd0 && !m_axis_tlast))
        else $error("format error transaction carries pixel data");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while previous transaction in progress");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pe <= r_total)
        else $error("pixel count exceeds image size");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sipd_pkg::ST_PUSH && out_free && !r_pix_lastrun) |-> (r_n < 4'd8))
        else $error("pixel run longer than eight");

endmodule

`default_nettype wire
